// File: rtl/mtb_pkg.sv
// ----------------------------------------------------------------------------
// mtb_pkg
// Types and codes shared by the timer bank core and its entry evaluator.
// ----------------------------------------------------------------------------
package mtb_pkg;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_INIT  = 3'd1,
    OP_START = 3'd2,
    OP_RESET = 3'd3,
    OP_STOP  = 3'd4,
    OP_QUERY = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    TT_DEFAULT = 2'd0,
    TT_AUTO    = 2'd1,
    TT_ONESHOT = 2'd2
  } tmr_type_e;

  // type code with no meaning, stored as a default timer
  localparam logic [1:0] TYPE_CODE_UNUSED = 2'b11;

  localparam logic KIND_EXPIRY = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam int unsigned HIT_W = 4;
  localparam logic [HIT_W-1:0] MAX_HITS = 4'd8;

  localparam int unsigned PERIOD_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ARM,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic [2:0]          op;
    logic [2:0]          timer_id;
    logic [1:0]          timer_type;
    logic [PERIOD_W-1:0] period;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] fired_id;
    logic       running;
    logic       last;
  } res_t;

  // verdict on one timer entry
  typedef struct packed {
    logic fire;
    logic keep_active;
    logic write_wake;
  } eval_t;

endpackage

// File: rtl/mtb_eval.sv
// ----------------------------------------------------------------------------
// mtb_eval
// Decides what happens to one timer entry: arm it, fire it at once, or on a
// tick check its wakeup time and re-arm or stop it.
// ----------------------------------------------------------------------------
module mtb_eval #(
  parameter int unsigned TICK_BITS = 16
) (
  input  logic                         is_tick_i,
  input  logic [1:0]                   ttype_i,
  input  logic [mtb_pkg::PERIOD_W-1:0] period_i,
  input  logic [TICK_BITS-1:0]         wake_i,
  input  logic                         active_i,
  input  logic [TICK_BITS-1:0]         now_i,
  output mtb_pkg::eval_t               eval_o,
  output logic [TICK_BITS-1:0]         wake_o
);

  logic                 p_zero;
  logic                 is_auto;
  logic                 immediate;
  logic                 hit;
  logic [TICK_BITS-1:0] p_eff;

  assign p_zero    = (period_i == '0);
  assign is_auto   = (ttype_i == mtb_pkg::TT_AUTO);
  // one-shot, or default with no period, fires on arming
  assign immediate = (ttype_i == mtb_pkg::TT_ONESHOT) ||
                     ((ttype_i == mtb_pkg::TT_DEFAULT) && p_zero);
  assign hit       = active_i && (wake_i == now_i);

  // period reduced to the counter width, zero taken as one for auto timers
  assign p_eff  = (is_auto && p_zero) ? TICK_BITS'(1) : TICK_BITS'(period_i);
  assign wake_o = now_i + p_eff;

  always_comb begin
    if (is_tick_i) begin
      eval_o.fire        = hit;
      eval_o.keep_active = hit ? is_auto : active_i;
      eval_o.write_wake  = hit && is_auto;
    end else begin
      eval_o.fire        = immediate;
      eval_o.keep_active = !immediate;
      eval_o.write_wake  = !immediate;
    end
  end

endmodule

// File: rtl/multi_timer_bank_core.sv
// ----------------------------------------------------------------------------
// multi_timer_bank_core
// Bank of software-style timers sharing one wrapping tick counter.
// ----------------------------------------------------------------------------
// A word is taken when start_i is high and busy_o is low. Init, stop, query
// and ignored words leave busy_o low; a query answer shows on res_o in the
// next cycle. Starting a timer not running and resetting a timer keep busy_o
// high while the timer entry is read back from the entry memory. A tick keeps
// busy_o high while the entry memory is swept one timer a cycle through its
// single read port, with the write-back of a re-armed timer overlapping the
// read of the next. Expiry words come out at most one a cycle with
// res_valid_o high for a single cycle each, at most eight per tick, the
// final one marked by last; the receiver must take every word as it appears.
// No clearing pass is needed after reset.
module multi_timer_bank_core #(
  parameter int unsigned NUM_TIMERS = 8,
  parameter int unsigned TICK_BITS  = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  mtb_pkg::req_t req_i,
  output logic          busy_o,
  output logic          res_valid_o,
  output mtb_pkg::res_t res_o
);

  localparam int unsigned IDX_W   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned PTR_W   = $clog2(NUM_TIMERS + 1);
  localparam int unsigned CMP_W   = (PTR_W > 3) ? PTR_W : 3;
  localparam int unsigned ENTRY_W = 2 + mtb_pkg::PERIOD_W + TICK_BITS;

  mtb_pkg::state_e state_q, state_d;

  logic [TICK_BITS-1:0]     now_q, now_d;
  logic [PTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic                     ev_valid_q, ev_valid_d;
  logic [IDX_W-1:0]         ev_idx_q, ev_idx_d;
  logic [mtb_pkg::HIT_W-1:0] hit_cnt_q, hit_cnt_d;
  logic                     pend_valid_q, pend_valid_d;
  logic [2:0]               pend_id_q, pend_id_d;
  logic [IDX_W-1:0]         arm_idx_q, arm_idx_d;
  logic [2:0]               arm_id_q, arm_id_d;
  logic [NUM_TIMERS-1:0]    active_q, active_d;
  logic [NUM_TIMERS-1:0]    written_q, written_d;
  logic                     out_valid_q, out_valid_d;
  mtb_pkg::res_t            out_q, out_d;

  // entry memory: {type, period, wakeup}
  logic [ENTRY_W-1:0] mem_q [NUM_TIMERS];
  logic [ENTRY_W-1:0] rdata_q;
  logic               rd_written_q;
  logic [IDX_W-1:0]   raddr;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;

  logic                         accept;
  logic                         id_ok;
  logic [IDX_W-1:0]             req_idx;
  logic                         arm_req;
  logic [1:0]                   init_type;
  logic [1:0]                   e_type;
  logic [mtb_pkg::PERIOD_W-1:0] e_period;
  logic [TICK_BITS-1:0]         e_wake;
  logic                         e_active;
  logic                         is_tick;
  logic                         scan_done;
  mtb_pkg::eval_t               ev;
  logic [TICK_BITS-1:0]         new_wake;

  assign accept    = start_i && (state_q == mtb_pkg::ST_IDLE);
  assign id_ok     = CMP_W'(req_i.timer_id) < CMP_W'(NUM_TIMERS);
  assign req_idx   = IDX_W'(req_i.timer_id);
  assign arm_req   = id_ok && (((req_i.op == mtb_pkg::OP_START) && !active_q[req_idx]) ||
                               (req_i.op == mtb_pkg::OP_RESET));
  assign init_type = (req_i.timer_type == mtb_pkg::TYPE_CODE_UNUSED) ?
                     mtb_pkg::TT_DEFAULT : req_i.timer_type;
  assign scan_done = (rd_ptr_q == PTR_W'(NUM_TIMERS));
  assign is_tick   = (state_q == mtb_pkg::ST_SCAN);

  // an entry never initialised reads as a default timer with no period
  assign e_type   = rd_written_q ? rdata_q[ENTRY_W-1 -: 2] : mtb_pkg::TT_DEFAULT;
  assign e_period = rd_written_q ? rdata_q[TICK_BITS +: mtb_pkg::PERIOD_W] : '0;
  assign e_wake   = rdata_q[TICK_BITS-1:0];
  assign e_active = active_q[ev_idx_q];

  assign raddr = (state_q == mtb_pkg::ST_IDLE) ? req_idx : rd_ptr_q[IDX_W-1:0];

  mtb_eval #(
    .TICK_BITS(TICK_BITS)
  ) u_eval (
    .is_tick_i(is_tick),
    .ttype_i  (e_type),
    .period_i (e_period),
    .wake_i   (e_wake),
    .active_i (e_active),
    .now_i    (now_q),
    .eval_o   (ev),
    .wake_o   (new_wake)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q      <= mem_q[raddr];
    rd_written_q <= written_q[raddr];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mtb_pkg::ST_IDLE: begin
        if (start_i) begin
          if (req_i.op == mtb_pkg::OP_TICK) begin
            state_d = mtb_pkg::ST_SCAN;
          end else if (arm_req) begin
            state_d = mtb_pkg::ST_ARM;
          end
        end
      end
      mtb_pkg::ST_ARM:   state_d = mtb_pkg::ST_IDLE;
      mtb_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = mtb_pkg::ST_FLUSH;
        end
      end
      mtb_pkg::ST_FLUSH: state_d = mtb_pkg::ST_IDLE;
      default:           state_d = mtb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    now_d        = now_q;
    rd_ptr_d     = rd_ptr_q;
    ev_valid_d   = ev_valid_q;
    ev_idx_d     = ev_idx_q;
    hit_cnt_d    = hit_cnt_q;
    pend_valid_d = pend_valid_q;
    pend_id_d    = pend_id_q;
    arm_idx_d    = arm_idx_q;
    arm_id_d     = arm_id_q;
    active_d     = active_q;
    written_d    = written_q;
    out_valid_d  = 1'b0;
    out_d        = out_q;
    we           = 1'b0;
    waddr        = ev_idx_q;
    wdata        = {e_type, e_period, new_wake};

    unique case (state_q)
      mtb_pkg::ST_IDLE: begin
        if (start_i) begin
          arm_idx_d = req_idx;
          arm_id_d  = req_i.timer_id;
          unique case (req_i.op)
            mtb_pkg::OP_TICK: begin
              now_d        = now_q + TICK_BITS'(1);
              rd_ptr_d     = '0;
              ev_valid_d   = 1'b0;
              hit_cnt_d    = '0;
              pend_valid_d = 1'b0;
            end
            mtb_pkg::OP_INIT: begin
              if (id_ok) begin
                we                 = 1'b1;
                waddr              = req_idx;
                wdata              = {init_type, req_i.period, now_q};
                written_d[req_idx] = 1'b1;
                active_d[req_idx]  = 1'b0;
              end
            end
            mtb_pkg::OP_STOP: begin
              if (id_ok) begin
                active_d[req_idx] = 1'b0;
              end
            end
            mtb_pkg::OP_QUERY: begin
              out_valid_d    = 1'b1;
              out_d.kind     = mtb_pkg::KIND_STATUS;
              out_d.fired_id = req_i.timer_id;
              out_d.running  = id_ok && active_q[req_idx];
              out_d.last     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      mtb_pkg::ST_ARM: begin
        if (ev.fire) begin
          active_d[arm_idx_q] = 1'b0;
          out_valid_d         = 1'b1;
          out_d.kind          = mtb_pkg::KIND_EXPIRY;
          out_d.fired_id      = arm_id_q;
          out_d.running       = 1'b0;
          out_d.last          = 1'b1;
        end else begin
          we                  = 1'b1;
          waddr               = arm_idx_q;
          active_d[arm_idx_q] = 1'b1;
        end
      end
      mtb_pkg::ST_SCAN: begin
        if (!scan_done) begin
          rd_ptr_d   = rd_ptr_q + PTR_W'(1);
          ev_valid_d = 1'b1;
          ev_idx_d   = rd_ptr_q[IDX_W-1:0];
        end else begin
          ev_valid_d = 1'b0;
        end
        // each expiry is held back until the next one or the flush so the final word can carry last
        if (ev_valid_q && (hit_cnt_q < mtb_pkg::MAX_HITS) && ev.fire) begin
          hit_cnt_d          = hit_cnt_q + mtb_pkg::HIT_W'(1);
          active_d[ev_idx_q] = ev.keep_active;
          we                 = ev.write_wake;
          pend_valid_d       = 1'b1;
          pend_id_d          = 3'(ev_idx_q);
          if (pend_valid_q) begin
            out_valid_d    = 1'b1;
            out_d.kind     = mtb_pkg::KIND_EXPIRY;
            out_d.fired_id = pend_id_q;
            out_d.running  = 1'b0;
            out_d.last     = 1'b0;
          end
        end
      end
      mtb_pkg::ST_FLUSH: begin
        if (pend_valid_q) begin
          out_valid_d    = 1'b1;
          out_d.kind     = mtb_pkg::KIND_EXPIRY;
          out_d.fired_id = pend_id_q;
          out_d.running  = 1'b0;
          out_d.last     = 1'b1;
        end
        pend_valid_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= mtb_pkg::ST_IDLE;
      now_q        <= '0;
      rd_ptr_q     <= '0;
      ev_valid_q   <= 1'b0;
      hit_cnt_q    <= '0;
      pend_valid_q <= 1'b0;
      active_q     <= '0;
      written_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      now_q        <= now_d;
      rd_ptr_q     <= rd_ptr_d;
      ev_valid_q   <= ev_valid_d;
      hit_cnt_q    <= hit_cnt_d;
      pend_valid_q <= pend_valid_d;
      active_q     <= active_d;
      written_q    <= written_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q  <= ev_idx_d;
    pend_id_q <= pend_id_d;
    arm_idx_q <= arm_idx_d;
    arm_id_q  <= arm_id_d;
    out_q     <= out_d;
  end

  assign busy_o      = (state_q != mtb_pkg::ST_IDLE);
  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  // a tick never reports more than eight expiries
  a_hit_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt_q <= mtb_pkg::MAX_HITS)
    else $error("tick expiry count beyond limit");

  // the sweep pointer stays within the bank
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_ptr_q <= PTR_W'(NUM_TIMERS))
    else $error("sweep pointer out of range");

  // arming only follows a taken word
  a_arm_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtb_pkg::ST_ARM) |-> $past(accept))
    else $error("arm state without a taken word");

  // a word not marked last always has a successor held back
  a_more_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_o.last) |-> pend_valid_q)
    else $error("non-final result with nothing pending");

endmodule
